[design/scaled_glyph_rect_generator_assert.svh]
// ----------------------------------------------------------------------------
// Scaled glyph rect generator assertion macros
// Concurrent-assertion shorthands for the block's RTL, used by sgr_core.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_RECT_GENERATOR_ASSERT_SVH
`define SCALED_GLYPH_RECT_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define SGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg
// Types, constants and the 5x7 column font for the glyph rect generator.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int FONT_WIDTH   = 5;
    localparam int FONT_HEIGHT  = 7;
    localparam int FONT_ADVANCE = 6;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int COORD_W = 16;
    localparam int SCALE_W = 8;
    localparam int MUL_W   = SCALE_W + 4;
    localparam int COL_W   = $clog2(FONT_WIDTH);
    localparam int ROW_W   = $clog2(FONT_HEIGHT);

    typedef logic [FONT_WIDTH-1:0][FONT_HEIGHT-1:0] t_glyph;

    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_COLOR  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_cfg;

    function automatic t_glyph mk_glyph(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [7:0] c4);
        mk_glyph = {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
    endfunction

    // Unknown codes fall back to '?'.
    function automatic t_glyph glyph_lookup(input logic [7:0] code);
        t_glyph g;
        unique case (code)
            8'h20:   g = mk_glyph(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            8'h2B:   g = mk_glyph(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
            8'h2D:   g = mk_glyph(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2E:   g = mk_glyph(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h2F:   g = mk_glyph(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            8'h3A:   g = mk_glyph(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h30:   g = mk_glyph(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31:   g = mk_glyph(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32:   g = mk_glyph(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33:   g = mk_glyph(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
            8'h34:   g = mk_glyph(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35:   g = mk_glyph(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36:   g = mk_glyph(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37:   g = mk_glyph(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38:   g = mk_glyph(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39:   g = mk_glyph(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            8'h41:   g = mk_glyph(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            8'h42:   g = mk_glyph(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43:   g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44:   g = mk_glyph(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45:   g = mk_glyph(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46:   g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47:   g = mk_glyph(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            8'h48:   g = mk_glyph(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49:   g = mk_glyph(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4A:   g = mk_glyph(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B:   g = mk_glyph(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C:   g = mk_glyph(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D:   g = mk_glyph(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E:   g = mk_glyph(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F:   g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50:   g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51:   g = mk_glyph(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52:   g = mk_glyph(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53:   g = mk_glyph(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54:   g = mk_glyph(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55:   g = mk_glyph(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56:   g = mk_glyph(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57:   g = mk_glyph(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            8'h58:   g = mk_glyph(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59:   g = mk_glyph(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            8'h5A:   g = mk_glyph(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            default: g = mk_glyph(8'h02, 8'h01, 8'h59, 8'h09, 8'h06);
        endcase
        return g;
    endfunction

endpackage

[design/sgr_cfg.sv]
// ----------------------------------------------------------------------------
// sgr_cfg
// APB register file: scale, canvas size and draw color.
// ----------------------------------------------------------------------------
module sgr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sgr_pkg::ADDR_W-1:0]  paddr,
    input  logic [sgr_pkg::DATA_W-1:0]  pwdata,
    output logic [sgr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output sgr_pkg::t_cfg               o_cfg
);
    import sgr_pkg::*;

    logic [SCALE_W-1:0] r_scale,  n_scale;
    logic [COORD_W-1:0] r_width,  n_width;
    logic [COORD_W-1:0] r_height, n_height;
    logic [COORD_W-1:0] r_color,  n_color;
    t_reg_idx           reg_idx;
    logic               wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_scale  = r_scale;
        n_width  = r_width;
        n_height = r_height;
        n_color  = r_color;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SCALE:  n_scale  = pwdata[SCALE_W-1:0];
                REG_WIDTH:  n_width  = pwdata[COORD_W-1:0];
                REG_HEIGHT: n_height = pwdata[COORD_W-1:0];
                REG_COLOR:  n_color  = pwdata[COORD_W-1:0];
                default:    n_scale  = r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_W'(1);
            r_width  <= COORD_W'(320);
            r_height <= COORD_W'(240);
            r_color  <= COORD_W'(16'hFFFF);
        end else begin
            r_scale  <= n_scale;
            r_width  <= n_width;
            r_height <= n_height;
            r_color  <= n_color;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SCALE:  prdata = DATA_W'(r_scale);
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_COLOR:  prdata = DATA_W'(r_color);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.scale  = r_scale;
    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;

endmodule

[design/sgr_core.sv]
// ----------------------------------------------------------------------------
// sgr_core
// Dot-scan sequencer with one shared adder, pending square and output register.
// ----------------------------------------------------------------------------
`include "scaled_glyph_rect_generator_assert.svh"

module sgr_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sgr_pkg::t_cfg                i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_first,
    input  logic [sgr_pkg::COORD_W-1:0]  i_start_x,
    input  logic [sgr_pkg::COORD_W-1:0]  i_start_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sgr_pkg::COORD_W-1:0]  o_rect_x,
    output logic [sgr_pkg::COORD_W-1:0]  o_rect_y,
    output logic                         o_last
);
    import sgr_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(FONT_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FONT_HEIGHT - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state             r_state,      n_state;
    logic               r_full,       n_full;
    logic [COORD_W-1:0] r_cursor,     n_cursor;
    logic [COORD_W-1:0] r_row_org,    n_row_org;
    t_glyph             r_glyph,      n_glyph;
    logic [COL_W-1:0]   r_col,        n_col;
    logic [ROW_W-1:0]   r_row,        n_row;
    logic [COORD_W-1:0] r_px,         n_px;
    logic [COORD_W-1:0] r_py,         n_py;
    logic               r_pend_valid, n_pend_valid;
    logic [COORD_W-1:0] r_pend_x,     n_pend_x;
    logic [COORD_W-1:0] r_pend_y,     n_pend_y;
    logic               r_out_valid,  n_out_valid;
    logic [COORD_W-1:0] r_out_x,      n_out_x;
    logic [COORD_W-1:0] r_out_y,      n_out_y;
    logic               r_out_last,   n_out_last;

    logic [COORD_W-1:0] add_a;
    logic [MUL_W-1:0]   add_b;
    logic [COORD_W:0]   add_sum;
    logic [MUL_W-1:0]   width_span;
    logic [MUL_W-1:0]   advance;
    logic               row_end;
    logic               col_end;
    logic               dot_vis;
    logic               out_free;
    logic               scan_hold;

    assign width_span = MUL_W'(i_cfg.scale) * MUL_W'(FONT_WIDTH);
    assign advance    = MUL_W'(i_cfg.scale) * MUL_W'(FONT_ADVANCE);
    assign row_end    = (r_row == ROW_LAST);
    assign col_end    = (r_col == COL_LAST);
    assign dot_vis    = r_glyph[r_col][r_row] && (r_px < i_cfg.width)
                        && (r_py < i_cfg.height);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_hold  = dot_vis && r_pend_valid && !out_free;

    // shared adder
    always_comb begin
        unique case (r_state)
            S_CHECK: begin
                add_a = r_cursor;
                add_b = width_span;
            end
            S_SCAN: begin
                add_a = row_end ? r_px : r_py;
                add_b = MUL_W'(i_cfg.scale);
            end
            S_FLUSH: begin
                add_a = r_cursor;
                add_b = advance;
            end
            default: begin
                add_a = r_cursor;
                add_b = '0;
            end
        endcase
        add_sum = {1'b0, add_a} + (COORD_W+1)'(add_b);
    end

    always_comb begin
        n_state      = r_state;
        n_full       = r_full;
        n_cursor     = r_cursor;
        n_row_org    = r_row_org;
        n_glyph      = r_glyph;
        n_col        = r_col;
        n_row        = r_row;
        n_px         = r_px;
        n_py         = r_py;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_last   = r_out_last;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_glyph = glyph_lookup(i_char_code);
                    if (i_first) begin
                        n_cursor  = i_start_x;
                        n_row_org = i_start_y;
                        n_full    = 1'b0;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_cfg.scale == '0 || r_full) begin
                    n_state = S_IDLE;
                end else if (add_sum > {1'b0, i_cfg.width}) begin
                    n_full  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_col   = '0;
                    n_row   = '0;
                    n_px    = r_cursor;
                    n_py    = r_row_org;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_hold) begin
                    if (dot_vis) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_x     = r_pend_x;
                            n_out_y     = r_pend_y;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_x     = r_px;
                        n_pend_y     = r_py;
                    end
                    if (row_end) begin
                        n_row = '0;
                        n_py  = r_row_org;
                        n_px  = add_sum[COORD_W-1:0];
                        if (col_end) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                    end else begin
                        n_row = r_row + ROW_W'(1);
                        n_py  = add_sum[COORD_W-1:0];
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_cursor = add_sum[COORD_W-1:0];
                    n_state  = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_x      = r_pend_x;
                    n_out_y      = r_pend_y;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_cursor     = add_sum[COORD_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_full       <= 1'b0;
            r_cursor     <= '0;
            r_row_org    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_full       <= n_full;
            r_cursor     <= n_cursor;
            r_row_org    <= n_row_org;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph    <= n_glyph;
        r_col      <= n_col;
        r_row      <= n_row;
        r_px       <= n_px;
        r_py       <= n_py;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rect_x    = r_out_x;
    assign o_rect_y    = r_out_y;
    assign o_last      = r_out_last;

    `SGR_ASSERT_IMP(a_pend_only_busy, i_clk, i_rst_n, r_pend_valid, (r_state == S_SCAN) || (r_state == S_FLUSH))
    `SGR_ASSERT_IMP(a_scan_idx_range, i_clk, i_rst_n, r_state == S_SCAN, (r_col <= COL_LAST) && (r_row <= ROW_LAST))
    `SGR_ASSERT_NXT(a_full_skips, i_clk, i_rst_n, (r_state == S_CHECK) && r_full, r_state == S_IDLE)
    `SGR_ASSERT_NXT(a_flush_empty, i_clk, i_rst_n, (r_state == S_FLUSH) && !r_pend_valid, (r_state == S_IDLE) && !r_pend_valid)

endmodule

[design/scaled_glyph_rect_generator.sv]
// ----------------------------------------------------------------------------
// scaled_glyph_rect_generator
// Draws text with a 5x7 column font as a stream of scaled square corners.
// ----------------------------------------------------------------------------
// One character item is taken when the block is idle. It then makes the
// right-edge check and steps the 35 font dots, one dot per cycle while the
// output side keeps up, through a single shared adder that walks x, y and the
// cursor, then releases the last square and advances the cursor. A character
// that is skipped (zero scale or past the edge) returns to idle after the
// check; output stalls slow a drawn character. Squares are emitted column by
// column; o_last marks the final square of a character. Registers sit at byte
// addresses 0 (scale), 4 (canvas width), 8 (canvas height), 12 (draw color).
module scaled_glyph_rect_generator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgr_pkg::ADDR_W-1:0]   paddr,
    input  logic [sgr_pkg::DATA_W-1:0]   pwdata,
    output logic [sgr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_first,
    input  logic [sgr_pkg::COORD_W-1:0]  i_start_x,
    input  logic [sgr_pkg::COORD_W-1:0]  i_start_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sgr_pkg::COORD_W-1:0]  o_rect_x,
    output logic [sgr_pkg::COORD_W-1:0]  o_rect_y,
    output logic                         o_last
);
    import sgr_pkg::*;

    t_cfg cfg;

    sgr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sgr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_first     (i_first),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rect_x    (o_rect_x),
        .o_rect_y    (o_rect_y),
        .o_last      (o_last)
    );

endmodule
